### design/gpc_pkg.sv
package gpc_pkg;
   localparam int MAX_ENTRIES_DEF = 4096;
   localparam int SIZE_W = 13;
   localparam int IDX_W = 12;
   localparam int NUM_W = 22;
   localparam int DIV_W = 14;
   localparam int QBITS = 8;
   localparam int CSR_IDX_W = 3;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_INVERSE = 2'd1;
   localparam logic [1:0] MODE_ZEBRA = 2'd2;
   localparam logic [1:0] MODE_MULTI = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_LOW = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_A = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_B = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_C = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_D = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE = 3'd7;

   typedef struct packed {
      logic [31:0] lo;
      logic [31:0] hi;
      logic [SIZE_W-1:0] r;
      logic [SIZE_W-1:0] d;
      logic oor;
   } gpc_item_type;
endpackage

### design/gpc_front.sv
module gpc_front import gpc_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_wdata,
   input  logic in_valid,
   output logic in_ready,
   input  logic [IDX_W-1:0] in_index,
   output logic head_valid,
   input  logic head_pop,
   output gpc_item_type head_item
);
   logic [1:0] mode_ff;
   logic [31:0] color_low_ff, color_high_ff, stop_a_ff, stop_b_ff, stop_c_ff, stop_d_ff;
   logic [SIZE_W-1:0] size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         color_low_ff <= 32'h0;
         color_high_ff <= 32'hFFFF_FFFF;
         stop_a_ff <= 32'h0;
         stop_b_ff <= 32'h0;
         stop_c_ff <= 32'h0;
         stop_d_ff <= 32'h0;
         size_ff <= SIZE_W'(256);
      end else if (csr_we) begin
         case (csr_index)
            REG_MODE: mode_ff <= csr_wdata[1:0];
            REG_COLOR_LOW: color_low_ff <= csr_wdata;
            REG_COLOR_HIGH: color_high_ff <= csr_wdata;
            REG_STOP_A: stop_a_ff <= csr_wdata;
            REG_STOP_B: stop_b_ff <= csr_wdata;
            REG_STOP_C: stop_c_ff <= csr_wdata;
            REG_STOP_D: stop_d_ff <= csr_wdata;
            REG_SIZE: size_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // classify the request
   localparam logic [16:0] MAX17 = 17'(MAX_ENTRIES);
   gpc_item_type item;
   logic [SIZE_W-1:0] s, dm;
   logic [SIZE_W+1:0] t3, d1, d2, rr;
   logic inv;

   always_comb begin
      s = ({4'b0, size_ff} > MAX17) ? MAX17[SIZE_W-1:0] : size_ff;
      dm = s - SIZE_W'(1);
      t3 = 15'({3'b0, in_index} * 3);
      d1 = {2'b0, dm};
      d2 = {1'b0, dm, 1'b0};
      inv = (mode_ff == MODE_INVERSE) || (mode_ff == MODE_ZEBRA && !in_index[0]);
      rr = '0;
      item.lo = color_low_ff;
      item.hi = color_high_ff;
      item.r = {1'b0, in_index};
      item.d = s;
      item.oor = 1'b0;
      if ({1'b0, in_index} >= s) begin
         item.lo = '0;
         item.hi = '0;
         item.r = '0;
         item.d = SIZE_W'(1);
         item.oor = 1'b1;
      end else if (mode_ff == MODE_MULTI) begin
         if (dm == '0) begin
            item.lo = stop_a_ff;
            item.hi = stop_a_ff;
            item.r = '0;
            item.d = SIZE_W'(1);
         end else begin
            if (t3 >= d2) begin
               item.lo = stop_c_ff;
               item.hi = stop_d_ff;
               rr = t3 - d2;
            end else if (t3 >= d1) begin
               item.lo = stop_b_ff;
               item.hi = stop_c_ff;
               rr = t3 - d1;
            end else begin
               item.lo = stop_a_ff;
               item.hi = stop_b_ff;
               rr = t3;
            end
            item.r = rr[SIZE_W-1:0];
            item.d = dm;
         end
      end else if (inv) begin
         item.lo = color_high_ff;
         item.hi = color_low_ff;
      end
   end

   // two-entry queue towards the back end
   gpc_item_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic push, pop;

   assign in_ready = (count_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign head_valid = (count_ff != 2'd0);
   assign pop = head_pop && head_valid;
   assign head_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wr_ptr_ff] <= item;
   end
endmodule

### design/gpc_back.sv
module gpc_back import gpc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic head_valid,
   output logic head_pop,
   input  gpc_item_type head_item,
   output logic out_valid,
   input  logic out_ready,
   output logic [31:0] out_color,
   output logic out_oor
);
   localparam int NST = QBITS + 1;

   logic [NUM_W-1:0] rem_ff [NST][4];
   logic [QBITS-1:0] q_ff [NST][4];
   logic [DIV_W-1:0] div_ff [NST];
   logic oor_ff [NST];
   logic vld_ff [NST];
   logic adv;

   assign adv = !vld_ff[NST-1] || out_ready;
   assign head_pop = adv;

   logic [NUM_W-1:0] n_in [4];
   logic [SIZE_W-1:0] w;
   always_comb begin
      w = head_item.d - head_item.r;
      for (int c = 0; c < 4; c++) begin
         n_in[c] = NUM_W'(({head_item.lo[c*8 +: 8]} * w + {head_item.hi[c*8 +: 8]} * head_item.r)
                   * 2) + NUM_W'(head_item.d);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NST; j++) vld_ff[j] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= head_valid;
         for (int j = 1; j < NST; j++) vld_ff[j] <= vld_ff[j-1];
      end
      if (adv) begin
         div_ff[0] <= {head_item.d, 1'b0};
         oor_ff[0] <= head_item.oor;
         for (int c = 0; c < 4; c++) begin
            rem_ff[0][c] <= n_in[c];
            q_ff[0][c] <= '0;
         end
         // one quotient bit per stage, most significant first
         for (int j = 1; j < NST; j++) begin
            div_ff[j] <= div_ff[j-1];
            oor_ff[j] <= oor_ff[j-1];
            for (int c = 0; c < 4; c++) begin
               if (rem_ff[j-1][c] >= (NUM_W'(div_ff[j-1]) << (QBITS - j))) begin
                  rem_ff[j][c] <= rem_ff[j-1][c] - (NUM_W'(div_ff[j-1]) << (QBITS - j));
                  q_ff[j][c] <= q_ff[j-1][c] | QBITS'(1 << (QBITS - j));
               end else begin
                  rem_ff[j][c] <= rem_ff[j-1][c];
                  q_ff[j][c] <= q_ff[j-1][c];
               end
            end
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_oor = oor_ff[NST-1];
   assign out_color = {q_ff[NST-1][3], q_ff[NST-1][2], q_ff[NST-1][1], q_ff[NST-1][0]};
endmodule

### design/gradient_palette_color.sv
// Path from request acceptance to result: the queue register, a blend stage and
// eight divider stages, one quotient bit per stage.
// Throughput: one request per cycle while rsp_tready is held high, set by the fully pipelined divider.
// Reset: synchronous, active high; registers return to their defaults and
// all pipeline and queue contents are dropped.
module gradient_palette_color import gpc_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_wdata,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [15:0] req_tdata,   // index[11:0], zero fill
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata,   // color[31:0]
   output logic rsp_tuser           // out_of_range
);
   gpc_item_type head_item;
   logic head_valid, head_pop;

   gpc_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_index(req_tdata[IDX_W-1:0]),
      .head_valid(head_valid), .head_pop(head_pop), .head_item(head_item)
   );

   gpc_back u_back (
      .clock(clock), .reset(reset),
      .head_valid(head_valid), .head_pop(head_pop), .head_item(head_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_color(rsp_tdata), .out_oor(rsp_tuser)
   );
endmodule

### design/gpc_checker.sv
module gpc_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic rsp_tuser
);
   logic [4:0] credit_ff;
   logic in_acc, out_acc;
   assign in_acc = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) credit_ff <= '0;
      else credit_ff <= credit_ff + 5'(in_acc) - 5'(out_acc);
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'h0)
      else $error("out-of-range result carries colour");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
   a_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> credit_ff != 5'd0)
      else $error("result without request");
endmodule

bind gradient_palette_color gpc_checker u_gpc_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
